// File: rtl/core/atcls_pkg.sv
// ----------------------------------------------------------------------------
// atcls_pkg
// Types, character codes and command codes shared by the link sequencer.
// ----------------------------------------------------------------------------
package atcls_pkg;

    localparam int LINE_MAX_DEFAULT = 32;
    localparam int STORE_DEPTH      = 15;
    localparam int QUEUE_DEPTH      = 2;
    localparam int TIMEOUT_W        = 7;
    localparam int CFG_INDEX_W      = 2;
    localparam int DIGITS           = 6;
    localparam int DIGIT_FIRST      = 9;

    localparam logic [TIMEOUT_W-1:0] SHORT_TIMEOUT_RESET = 7'd2;
    localparam logic [TIMEOUT_W-1:0] LONG_TIMEOUT_RESET  = 7'd10;

    localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_TIMEOUT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_TIMEOUT  = 2'd1;

    localparam logic [7:0] CHAR_O    = 8'h4F;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NL   = 8'h0A;

    localparam logic [39:0] STR_READY = "ready";
    localparam logic [39:0] STR_INVAL = "inval";
    localparam logic [31:0] STR_IPD   = "+IPD";

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_ALIVE   = 3'd1,
        CMD_STATION = 3'd2,
        CMD_JOIN    = 3'd3,
        CMD_MULTI   = 3'd4,
        CMD_SERVER  = 3'd5,
        CMD_CONNECT = 3'd6
    } cmd_t;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic       send_valid;
        logic [2:0] send_command;
        logic       time_valid;
        logic [7:0] hour_tens;
        logic [7:0] hour_units;
        logic [7:0] minute_tens;
        logic [7:0] minute_units;
        logic [7:0] second_tens;
        logic [7:0] second_units;
        logic       module_reset;
        logic       power_down;
    } result_t;

    // Classified word passed from the line assembler to the sequencer.
    typedef struct packed {
        logic                        is_tick;
        logic                        is_line;
        logic                        ready_or_inval;
        logic                        first_o;
        logic                        ipd;
        logic [DIGITS-1:0][7:0]      digits;
    } event_t;

endpackage

// File: rtl/core/at_command_link_sequencer.sv
// ----------------------------------------------------------------------------
// at_command_link_sequencer
// Bring-up sequencer for a serial wireless module, fed with bytes and ticks.
// ----------------------------------------------------------------------------
// Each input word is either a received byte or a one-second tick. A word is
// taken when push is high and full is low; every word yields exactly one
// result word, held on result while empty is low and taken when pop is high.
// The line assembler classifies each word in the cycle it is taken and
// writes it to a two-word queue; the sequencer takes one word a cycle from
// that queue while the output queue has room and writes its result to a
// two-word output queue, so a result is registered in both queues in turn.
// One word is taken per cycle as long as pop keeps up with it. When pop stays
// low the output queue fills, then the inner queue, and full rises; nothing
// is lost. Reset clears both queues and the line, sets the reply timer to the
// long timeout and the timeout registers to their defaults. The configuration
// channel is always ready; writes are meant for idle periods only.
// ----------------------------------------------------------------------------
module at_command_link_sequencer #(
    parameter int LINE_MAX = atcls_pkg::LINE_MAX_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  atcls_pkg::item_t                   item,
    output logic                               empty,
    input  logic                               pop,
    output atcls_pkg::result_t                 result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [atcls_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [atcls_pkg::TIMEOUT_W-1:0]    cfg_data
);

    atcls_pkg::event_t  front_ev;
    atcls_pkg::event_t  mid_ev;
    atcls_pkg::result_t back_result;
    logic               accept;
    logic               mid_empty;
    logic               out_full;
    logic               advance;

    assign accept    = push && !full;
    assign advance   = !mid_empty && !out_full;
    assign cfg_ready = 1'b1;

    atcls_front #(
        .LINE_MAX (LINE_MAX)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .ev     (front_ev)
    );

    atcls_fifo #(
        .WIDTH ($bits(atcls_pkg::event_t)),
        .DEPTH (atcls_pkg::QUEUE_DEPTH)
    ) u_mid_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .data_in  (front_ev),
        .full     (full),
        .pop      (advance),
        .data_out (mid_ev),
        .empty    (mid_empty)
    );

    atcls_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .ev        (mid_ev),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (back_result)
    );

    atcls_fifo #(
        .WIDTH ($bits(atcls_pkg::result_t)),
        .DEPTH (atcls_pkg::QUEUE_DEPTH)
    ) u_out_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (advance),
        .data_in  (back_result),
        .full     (out_full),
        .pop      (pop),
        .data_out (result),
        .empty    (empty)
    );

    // A taken word is always waiting in the inner queue on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !mid_empty)
    else $error("accepted word missing from inner queue");

    // A word moved by the sequencer is always waiting in the output queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> !empty)
    else $error("sequenced word missing from output queue");

    // A command code appears exactly when a command is requested.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.send_valid == (result.send_command != atcls_pkg::CMD_NONE)))
    else $error("command code and request disagree");

    // Time digits always come with the power-down request and nothing else.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((result.time_valid == result.power_down) &&
                    !(result.time_valid && (result.send_valid || result.module_reset))))
    else $error("inconsistent result flags");

endmodule

// File: rtl/core/atcls_fifo.sv
// ----------------------------------------------------------------------------
// atcls_fifo
// Small register queue between the stages of the link sequencer.
// ----------------------------------------------------------------------------
module atcls_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] data_in,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] data_out,
    output logic             empty
);

    // DEPTH is a power of two, so the pointers wrap by themselves.
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign data_out = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= data_in;
        end
    end

endmodule

// File: rtl/core/atcls_front.sv
// ----------------------------------------------------------------------------
// atcls_front
// Line assembler: gathers received bytes into a line and classifies it.
// ----------------------------------------------------------------------------
module atcls_front #(
    parameter int LINE_MAX = atcls_pkg::LINE_MAX_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  atcls_pkg::item_t   item,
    output atcls_pkg::event_t  ev
);

    localparam int CNT_W = $clog2(LINE_MAX);

    logic [7:0]       store_reg  [atcls_pkg::STORE_DEPTH];
    logic [7:0]       store_next [atcls_pkg::STORE_DEPTH];
    logic [7:0]       line       [atcls_pkg::STORE_DEPTH];
    logic [CNT_W-1:0] count_reg, count_next;
    logic             is_byte;
    logic             is_nl;
    logic             room;
    logic             match_ready;
    logic             match_inval;
    logic             match_ipd;

    assign is_byte = !item.action;
    assign is_nl   = is_byte && (item.rx_byte == atcls_pkg::CHAR_NL);
    assign room    = (count_reg < CNT_W'(LINE_MAX - 1));

    // The line as it stands once this byte is written; the store always lies
    // below the count limit, so a matching count alone selects the entry.
    always_comb
    begin
        for (int i = 0; i < atcls_pkg::STORE_DEPTH; i++)
        begin
            if (is_byte && (count_reg == CNT_W'(i)))
            begin
                line[i] = item.rx_byte;
            end
            else
            begin
                line[i] = store_reg[i];
            end
        end
    end

    always_comb
    begin
        match_ready = 1'b1;
        match_inval = 1'b1;
        match_ipd   = 1'b1;
        for (int i = 0; i < 5; i++)
        begin
            if (line[i] != atcls_pkg::STR_READY[8*(4-i) +: 8])
            begin
                match_ready = 1'b0;
            end
            if (line[i] != atcls_pkg::STR_INVAL[8*(4-i) +: 8])
            begin
                match_inval = 1'b0;
            end
        end
        for (int i = 0; i < 4; i++)
        begin
            if (line[i] != atcls_pkg::STR_IPD[8*(3-i) +: 8])
            begin
                match_ipd = 1'b0;
            end
        end
    end

    always_comb
    begin
        ev.is_tick        = item.action;
        ev.is_line        = is_nl;
        ev.ready_or_inval = match_ready || match_inval;
        ev.first_o        = (line[0] == atcls_pkg::CHAR_O);
        ev.ipd            = match_ipd;
        for (int i = 0; i < atcls_pkg::DIGITS; i++)
        begin
            ev.digits[atcls_pkg::DIGITS-1-i] =
                line[atcls_pkg::DIGIT_FIRST + i] - atcls_pkg::CHAR_ZERO;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        for (int i = 0; i < atcls_pkg::STORE_DEPTH; i++)
        begin
            store_next[i] = store_reg[i];
        end
        if (is_nl)
        begin
            count_next = '0;
            for (int i = 0; i < atcls_pkg::STORE_DEPTH; i++)
            begin
                store_next[i] = 8'h00;
            end
        end
        else if (is_byte)
        begin
            for (int i = 0; i < atcls_pkg::STORE_DEPTH; i++)
            begin
                store_next[i] = line[i];
            end
            if (room)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            for (int i = 0; i < atcls_pkg::STORE_DEPTH; i++)
            begin
                store_reg[i] <= 8'h00;
            end
        end
        else if (accept)
        begin
            count_reg <= count_next;
            for (int i = 0; i < atcls_pkg::STORE_DEPTH; i++)
            begin
                store_reg[i] <= store_next[i];
            end
        end
    end

endmodule

// File: rtl/core/atcls_back.sv
// ----------------------------------------------------------------------------
// atcls_back
// Command sequencer: walks the bring-up sequence and runs the reply timer.
// ----------------------------------------------------------------------------
module atcls_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 advance,
    input  atcls_pkg::event_t                    ev,
    input  logic                                 cfg_write,
    input  logic [atcls_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [atcls_pkg::TIMEOUT_W-1:0]      cfg_data,
    output atcls_pkg::result_t                   result
);

    logic [atcls_pkg::TIMEOUT_W-1:0] short_reg;
    logic [atcls_pkg::TIMEOUT_W-1:0] long_reg;
    logic [atcls_pkg::TIMEOUT_W-1:0] left_reg, left_next;
    atcls_pkg::cmd_t                 last_reg, last_next;
    atcls_pkg::cmd_t                 issue_cmd;
    logic                            issue;
    logic                            in_sequence;

    assign in_sequence = (last_reg == atcls_pkg::CMD_ALIVE)   ||
                         (last_reg == atcls_pkg::CMD_STATION) ||
                         (last_reg == atcls_pkg::CMD_JOIN)    ||
                         (last_reg == atcls_pkg::CMD_MULTI)   ||
                         (last_reg == atcls_pkg::CMD_SERVER);

    always_comb
    begin
        issue     = 1'b0;
        issue_cmd = atcls_pkg::CMD_NONE;
        if (!ev.is_tick && ev.is_line)
        begin
            if (ev.ready_or_inval)
            begin
                issue     = 1'b1;
                issue_cmd = atcls_pkg::CMD_ALIVE;
            end
            else if (in_sequence && ev.first_o)
            begin
                issue     = 1'b1;
                issue_cmd = atcls_pkg::cmd_t'(last_reg + 3'd1);
            end
        end
    end

    always_comb
    begin
        result    = '0;
        left_next = left_reg;
        last_next = last_reg;
        if (ev.is_tick)
        begin
            if (left_reg != '0)
            begin
                left_next           = left_reg - 1'b1;
                result.module_reset = (left_reg == atcls_pkg::TIMEOUT_W'(1));
            end
        end
        else if (issue)
        begin
            last_next           = issue_cmd;
            left_next           = (issue_cmd == atcls_pkg::CMD_JOIN) ? long_reg : short_reg;
            result.send_valid   = 1'b1;
            result.send_command = issue_cmd;
        end
        else if (ev.is_line && (last_reg == atcls_pkg::CMD_CONNECT))
        begin
            if (ev.first_o)
            begin
                left_next = '0;
            end
            else if (ev.ipd)
            begin
                result.time_valid   = 1'b1;
                result.hour_tens    = ev.digits[5];
                result.hour_units   = ev.digits[4];
                result.minute_tens  = ev.digits[3];
                result.minute_units = ev.digits[2];
                result.second_tens  = ev.digits[1];
                result.second_units = ev.digits[0];
                result.power_down   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= atcls_pkg::LONG_TIMEOUT_RESET;
            last_reg <= atcls_pkg::CMD_NONE;
        end
        else if (advance)
        begin
            left_reg <= left_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_reg <= atcls_pkg::SHORT_TIMEOUT_RESET;
            long_reg  <= atcls_pkg::LONG_TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == atcls_pkg::CFG_SHORT_TIMEOUT)
            begin
                short_reg <= cfg_data;
            end
            else if (cfg_index == atcls_pkg::CFG_LONG_TIMEOUT)
            begin
                long_reg <= cfg_data;
            end
        end
    end

endmodule

// File: test/tb_at_command_link_sequencer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_at_command_link_sequencer
// Self-checking bench for the bring-up sequencer of the serial link.
// ----------------------------------------------------------------------------
// Bytes and ticks are pushed into the block, and every result word popped
// from it is checked against a predictor held in a small scoreboard class.
// A short directed opening is followed by random traffic, which is mostly
// well-formed bring-up dialogue: ready lines, OK answers, data lines with
// time digits and timer ticks. Noise, over-long lines and broken lines are
// mixed in. The timeout registers are changed between phases, including
// their extremes. Both sides idle at random, and one phase holds the result
// side off for long enough that the input side stalls.
// ----------------------------------------------------------------------------
module tb_at_command_link_sequencer;

    localparam int             LINE_LIMIT   = atcls_pkg::LINE_MAX_DEFAULT;
    localparam int             RANDOM_WORDS = 1850;
    localparam int             PHASES       = 8;
    localparam int             CYCLE_LIMIT  = 400000;
    localparam int             HOLD_CYCLES  = 120;
    localparam logic [7:0]     CHAR_CR      = 8'h0D;
    // Register indexes that the block does not decode.
    localparam logic [atcls_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [atcls_pkg::CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

    class link_scoreboard;
        logic [7:0]                      line_bytes [atcls_pkg::STORE_DEPTH];
        int unsigned                     line_len;
        atcls_pkg::cmd_t                 last_cmd;
        logic [atcls_pkg::TIMEOUT_W-1:0] ticks_left;
        logic [atcls_pkg::TIMEOUT_W-1:0] short_ticks;
        logic [atcls_pkg::TIMEOUT_W-1:0] long_ticks;
        atcls_pkg::result_t              awaited [$];
        int                              mismatches;
        int                              strays;
        int                              reported;
        int                              ticks_seen;
        int                              results_seen;
        int                              commands_seen;
        int                              times_seen;
        int                              resets_seen;

        function new();
            int i;
            for (i = 0; i < atcls_pkg::STORE_DEPTH; i++)
                line_bytes[i] = 8'h00;
            line_len      = 0;
            last_cmd      = atcls_pkg::CMD_NONE;
            short_ticks   = atcls_pkg::SHORT_TIMEOUT_RESET;
            long_ticks    = atcls_pkg::LONG_TIMEOUT_RESET;
            ticks_left    = atcls_pkg::LONG_TIMEOUT_RESET;
            mismatches    = 0;
            strays        = 0;
            reported      = 0;
            ticks_seen    = 0;
            results_seen  = 0;
            commands_seen = 0;
            times_seen    = 0;
            resets_seen   = 0;
        endfunction

        function void write_register(input logic [atcls_pkg::CFG_INDEX_W-1:0] idx,
                                     input logic [atcls_pkg::TIMEOUT_W-1:0] value);
            if (idx == atcls_pkg::CFG_SHORT_TIMEOUT)
                short_ticks = value;
            else if (idx == atcls_pkg::CFG_LONG_TIMEOUT)
                long_ticks = value;
        endfunction

        // The pattern is right-aligned: its first character sits in the
        // highest byte of the n bytes used.
        function bit begins_with(input logic [39:0] pattern, input int n);
            int i;
            for (i = 0; i < n; i++)
                if (line_bytes[i] != pattern[8*(n-1-i) +: 8])
                    return 1'b0;
            return 1'b1;
        endfunction

        function atcls_pkg::result_t issue_command(input atcls_pkg::cmd_t c);
            atcls_pkg::result_t r;
            r = '0;
            last_cmd = c;
            ticks_left = (c == atcls_pkg::CMD_JOIN) ? long_ticks : short_ticks;
            r.send_valid = 1'b1;
            r.send_command = c;
            return r;
        endfunction

        function atcls_pkg::result_t finish_line();
            atcls_pkg::result_t r;
            logic [7:0]         d [atcls_pkg::DIGITS];
            int                 i;
            r = '0;
            if (begins_with(atcls_pkg::STR_READY, 5) || begins_with(atcls_pkg::STR_INVAL, 5))
            begin
                r = issue_command(atcls_pkg::CMD_ALIVE);
            end
            else if (last_cmd >= atcls_pkg::CMD_ALIVE && last_cmd <= atcls_pkg::CMD_SERVER)
            begin
                if (line_bytes[0] == atcls_pkg::CHAR_O)
                    r = issue_command(atcls_pkg::cmd_t'(last_cmd + 3'd1));
            end
            else if (last_cmd == atcls_pkg::CMD_CONNECT)
            begin
                if (line_bytes[0] == atcls_pkg::CHAR_O)
                begin
                    ticks_left = '0;
                end
                else if (begins_with({8'h00, atcls_pkg::STR_IPD}, 4))
                begin
                    for (i = 0; i < atcls_pkg::DIGITS; i++)
                        d[i] = line_bytes[atcls_pkg::DIGIT_FIRST + i] - atcls_pkg::CHAR_ZERO;
                    r.time_valid   = 1'b1;
                    r.hour_tens    = d[0];
                    r.hour_units   = d[1];
                    r.minute_tens  = d[2];
                    r.minute_units = d[3];
                    r.second_tens  = d[4];
                    r.second_units = d[5];
                    r.power_down   = 1'b1;
                end
            end
            return r;
        endfunction

        function void accept_word(input atcls_pkg::item_t w);
            atcls_pkg::result_t r;
            int                 i;
            r = '0;
            if (w.action)
            begin
                ticks_seen++;
                if (ticks_left != 0)
                begin
                    ticks_left--;
                    if (ticks_left == 0)
                        r.module_reset = 1'b1;
                end
            end
            else
            begin
                // Bytes past the counting limit are dropped, but a newline
                // still closes the line.
                if (line_len < LINE_LIMIT - 1)
                begin
                    if (line_len < atcls_pkg::STORE_DEPTH)
                        line_bytes[line_len] = w.rx_byte;
                    line_len++;
                end
                if (w.rx_byte == atcls_pkg::CHAR_NL)
                begin
                    r = finish_line();
                    for (i = 0; i < atcls_pkg::STORE_DEPTH; i++)
                        line_bytes[i] = 8'h00;
                    line_len = 0;
                end
            end
            awaited.push_back(r);
        endfunction

        function string describe(input atcls_pkg::result_t r);
            return {$sformatf("cmd %0b/%0d time %0b %0d %0d %0d",
                              r.send_valid, r.send_command, r.time_valid,
                              r.hour_tens, r.hour_units, r.minute_tens),
                    $sformatf(" %0d %0d %0d reset %0b down %0b",
                              r.minute_units, r.second_tens, r.second_units,
                              r.module_reset, r.power_down)};
        endfunction

        function void check_result(input atcls_pkg::result_t got);
            atcls_pkg::result_t want;
            string              diffs;
            results_seen++;
            if (awaited.size() == 0)
            begin
                strays++;
                reported++;
                if (reported <= 10)
                    $display("Unexpected result word: %s", describe(got));
                return;
            end
            want = awaited.pop_front();
            diffs = "";
            if (got.send_valid !== want.send_valid)     diffs = {diffs, " send_valid"};
            if (got.send_command !== want.send_command) diffs = {diffs, " send_command"};
            if (got.time_valid !== want.time_valid)     diffs = {diffs, " time_valid"};
            if (got.hour_tens !== want.hour_tens)       diffs = {diffs, " hour_tens"};
            if (got.hour_units !== want.hour_units)     diffs = {diffs, " hour_units"};
            if (got.minute_tens !== want.minute_tens)   diffs = {diffs, " minute_tens"};
            if (got.minute_units !== want.minute_units) diffs = {diffs, " minute_units"};
            if (got.second_tens !== want.second_tens)   diffs = {diffs, " second_tens"};
            if (got.second_units !== want.second_units) diffs = {diffs, " second_units"};
            if (got.module_reset !== want.module_reset) diffs = {diffs, " module_reset"};
            if (got.power_down !== want.power_down)     diffs = {diffs, " power_down"};
            if (diffs != "")
            begin
                mismatches++;
                reported++;
                if (reported <= 10)
                    $display("Mismatch in%s: expected %s, got %s",
                             diffs, describe(want), describe(got));
            end
            if (want.send_valid)   commands_seen++;
            if (want.time_valid)   times_seen++;
            if (want.module_reset) resets_seen++;
        endfunction
    endclass

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              push      = 1'b0;
    logic                              full;
    atcls_pkg::item_t                  item      = '0;
    logic                              empty;
    logic                              pop       = 1'b0;
    atcls_pkg::result_t                result;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [atcls_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [atcls_pkg::TIMEOUT_W-1:0]   cfg_data  = '0;

    link_scoreboard       sb;
    logic [7:0]           line_buf [$];
    int                   items_sent    = 0;
    int                   cycle_count   = 0;
    int                   hold_request  = 0;
    bit                   calm          = 1'b0;
    bit                   sender_bursty = 1'b1;
    bit                   drain_bursty  = 1'b1;

    at_command_link_sequencer #(
        .LINE_MAX (LINE_LIMIT)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic atcls_pkg::item_t make_word(input logic act, input logic [7:0] b);
        atcls_pkg::item_t w;
        w.action  = act;
        w.rx_byte = b;
        return w;
    endfunction

    task automatic send_item(input atcls_pkg::item_t w);
        int gap;
        if (sender_bursty && !calm && $urandom_range(0, 11) == 0)
        begin
            gap = $urandom_range(1, 13);
            @(negedge clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        push <= 1'b1;
        item <= w;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.accept_word(w);
        items_sent++;
    endtask

    task automatic write_register(input logic [atcls_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [atcls_pkg::TIMEOUT_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_register(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering words and wait until every predicted result has been
    // popped, then let the clock run on before returning.
    task automatic settle();
        @(negedge clk);
        push <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task automatic add_printable(input int n);
        repeat (n) line_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
    endtask

    task automatic flush_line();
        int i;
        for (i = 0; i < line_buf.size(); i++)
            send_item(make_word(1'b0, line_buf[i]));
        line_buf.delete();
    endtask

    task automatic end_line(input bit crlf);
        if (crlf)
            line_buf.push_back(CHAR_CR);
        line_buf.push_back(atcls_pkg::CHAR_NL);
        flush_line();
    endtask

    // A data line carrying the time digits at positions 9 to 14; now and
    // then it is cut short, so that the digits fall on cleared positions.
    task automatic add_time_line();
        int         i;
        int         keep;
        logic [7:0] dropped;
        add_text("+IPD");
        if ($urandom_range(0, 3) != 0)
            add_text(",0,9:");
        else
            add_printable(5);
        for (i = 0; i < atcls_pkg::DIGITS; i++)
            line_buf.push_back(($urandom_range(0, 4) != 0)
                               ? atcls_pkg::CHAR_ZERO + 8'($urandom_range(0, 9))
                               : 8'($urandom));
        if ($urandom_range(0, 6) == 0)
        begin
            keep = $urandom_range(4, 14);
            while (line_buf.size() > keep)
                dropped = line_buf.pop_back();
        end
        else
        begin
            add_printable($urandom_range(0, 20));
        end
    endtask

    task automatic random_step();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            repeat (n) send_item(make_word(1'b1, 8'($urandom)));
        end
        else if (pick < 16)
        begin
            repeat ($urandom_range(0, 20)) line_buf.push_back(8'($urandom));
            end_line(1'b0);
        end
        else if (pick < 19)
        begin
            add_printable($urandom_range(LINE_LIMIT, LINE_LIMIT + 14));
            end_line(1'($urandom_range(0, 1)));
        end
        else if (pick < 21)
        begin
            // A fragment with no line end runs on into the next line.
            add_printable($urandom_range(1, 8));
            flush_line();
        end
        else if (pick < 30 || (sb.last_cmd == atcls_pkg::CMD_NONE && pick < 80))
        begin
            add_text($urandom_range(0, 1) ? "ready" : "inval");
            add_printable($urandom_range(0, 8));
            end_line(1'($urandom_range(0, 1)));
        end
        else if (sb.last_cmd == atcls_pkg::CMD_CONNECT)
        begin
            if (pick < 65)
                add_time_line();
            else if (pick < 85)
            begin
                add_text("O");
                add_printable($urandom_range(0, 3));
            end
            else
                add_printable($urandom_range(1, 12));
            end_line(1'($urandom_range(0, 1)));
        end
        else if (sb.last_cmd != atcls_pkg::CMD_NONE && pick < 88)
        begin
            add_text($urandom_range(0, 3) != 0 ? "OK" : "O");
            add_printable($urandom_range(0, 4));
            end_line(1'($urandom_range(0, 1)));
        end
        else
        begin
            if ($urandom_range(0, 1))
                add_time_line();
            else
                add_text("ERROR");
            end_line(1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin : result_drain
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (drain_bursty && !calm && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
            @(posedge clk);
            if (rst_n && pop && !empty)
                sb.check_result(result);
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk) cycle_count++;
        $display("at_command_link_sequencer test failed");
        $finish;
    end

    initial
    begin : stimulus
        int                              p;
        int                              base;
        int                              target;
        bit                              saved;
        logic [atcls_pkg::TIMEOUT_W-1:0] short_val;
        logic [atcls_pkg::TIMEOUT_W-1:0] long_val;
        sb = new;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Writes to undecoded indexes must leave both timeouts alone.
        write_register(CFG_SPARE_LO, 7'h7F);
        write_register(CFG_SPARE_HI, 7'h00);

        // Directed opening: tick and byte extremes, a line of those bytes before any
        // command, an inval line, an unanswered line, an O answer, then the
        // short timeout running out and a tick on the stopped timer.
        send_item(make_word(1'b1, 8'hFF));
        send_item(make_word(1'b0, 8'h00));
        send_item(make_word(1'b0, 8'hFF));
        send_item(make_word(1'b0, atcls_pkg::CHAR_NL));
        add_text("inval");
        end_line(1'b0);
        add_text("x");
        end_line(1'b0);
        add_text("O");
        end_line(1'b0);
        repeat (3) send_item(make_word(1'b1, 8'h00));

        base = items_sent;
        for (p = 0; p < PHASES; p++)
        begin
            settle();
            case (p)
                0:       begin short_val = 7'd1;   long_val = 7'd1;   end
                1:       begin short_val = 7'd127; long_val = 7'd127; end
                // Zero in both registers means the timer never runs.
                2:       begin short_val = 7'd0;   long_val = 7'd0;   end
                3:       begin short_val = 7'($urandom_range(1, 127));
                               long_val  = 7'($urandom_range(1, 127)); end
                4:       begin short_val = 7'd3;   long_val = 7'd127; end
                5:       begin short_val = 7'd127; long_val = 7'd1;   end
                6:       begin short_val = 7'($urandom_range(1, 8));
                               long_val  = 7'($urandom_range(1, 8));  end
                default: begin short_val = atcls_pkg::SHORT_TIMEOUT_RESET;
                               long_val  = atcls_pkg::LONG_TIMEOUT_RESET;  end
            endcase
            write_register(atcls_pkg::CFG_SHORT_TIMEOUT, short_val);
            write_register(atcls_pkg::CFG_LONG_TIMEOUT, long_val);
            calm = (p == PHASES - 1);
            sender_bursty = !calm && ($urandom_range(0, 3) != 0);
            drain_bursty  = !calm && ($urandom_range(0, 3) != 0);

            if (p == 3)
            begin
                // Hold the result side off while words keep coming, so that
                // both queues fill and full rises; then wait for the backlog.
                hold_request = HOLD_CYCLES;
                saved = sender_bursty;
                sender_bursty = 1'b0;
                repeat (4)
                begin
                    add_text("ready");
                    end_line(1'b1);
                    add_text("OK");
                    end_line(1'b1);
                end
                sender_bursty = saved;
                settle();
            end

            target = base + (p + 1) * RANDOM_WORDS / PHASES;
            while (items_sent < target)
                random_step();
        end

        @(negedge clk);
        push <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Covered %0d words (%0d ticks, %0d bytes) over %0d timeout settings,",
                 items_sent, sb.ticks_seen, items_sent - sb.ticks_seen, PHASES);
        $display("%0d results checked: commands %0d, time reports %0d, module resets %0d;",
                 sb.results_seen, sb.commands_seen, sb.times_seen, sb.resets_seen);
        $display("%0d bad, %0d unexpected.", sb.mismatches, sb.strays);
        if (sb.mismatches == 0 && sb.strays == 0 && sb.awaited.size() == 0)
            $display("at_command_link_sequencer test passed");
        else
            $display("at_command_link_sequencer test failed");
        $finish;
    end

endmodule
